/* hw/rtl/particle_euler_bounce_step_defines.svh */
// assertion macros for the particle euler bounce step block
// expects a clock i_clk and an active-low reset i_rst_n in the using module
`ifndef PARTICLE_EULER_BOUNCE_STEP_DEFINES_SVH
`define PARTICLE_EULER_BOUNCE_STEP_DEFINES_SVH

// same-cycle implication
`define PEB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("particle step assertion failed");

// next-cycle implication
`define PEB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("particle step assertion failed");

`endif

/* hw/rtl/peb_pkg.sv */
// package for the particle euler bounce step block
// holds payload structs, register indexes, fixed-point constants and saturation
package peb_pkg;

    localparam int CfgAddrW = 1;

    localparam logic [CfgAddrW-1:0] CFG_TIME_SCALE = 1'b0;
    localparam logic [CfgAddrW-1:0] CFG_GRAVITY    = 1'b1;

    localparam logic [23:0]        TIME_SCALE_RST = 24'd65536;
    localparam logic signed [31:0] GRAVITY_RST    = -32'sd642908;
    localparam logic [16:0]        BOUNCE_Q16     = 17'd45875;
    localparam logic signed [31:0] RESPAWN_Y      = 32'sd1310720;
    localparam logic [16:0]        LIFE_FULL      = 17'd65536;

    typedef struct packed {
        logic [15:0]        frame_time;
        logic signed [31:0] pos_x_in;
        logic signed [31:0] pos_y_in;
        logic signed [31:0] pos_z_in;
        logic signed [31:0] vel_x_in;
        logic signed [31:0] vel_y_in;
        logic signed [31:0] vel_z_in;
        logic [16:0]        life_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x_out;
        logic signed [31:0] pos_y_out;
        logic signed [31:0] pos_z_out;
        logic signed [31:0] vel_x_out;
        logic signed [31:0] vel_y_out;
        logic signed [31:0] vel_z_out;
        logic [16:0]        life_out;
    } t_out_item;

    // clamp a 42-bit signed sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v[41:31] == {11{1'b0}} || v[41:31] == {11{1'b1}}) begin
            r = v[31:0];
        end else if (v[41]) begin
            r = {1'b1, {31{1'b0}}};
        end else begin
            r = {1'b0, {31{1'b1}}};
        end
        return r;
    endfunction

    // a + (b >>> 16 result), both sign extended to 42 bits
    function automatic logic signed [41:0] add_term(input logic signed [31:0] a,
                                                     input logic signed [40:0] b);
        return $signed({{10{a[31]}}, a}) + $signed({b[40], b});
    endfunction

    // signed 32 by unsigned 24 product, floor divided by 65536
    function automatic logic signed [40:0] mul_step(input logic signed [31:0] a,
                                                     input logic [23:0] s);
        logic signed [56:0] p;
        p = $signed({{25{a[31]}}, a}) * $signed({33'd0, s});
        return p[56:16];
    endfunction

endpackage

/* hw/rtl/particle_euler_bounce_step.sv */
// particle euler bounce step: top level, five-stage pipeline
// depends on peb_pkg and particle_euler_bounce_step_defines.svh
// throughput: one particle per cycle; a stall freezes all five stages together
// multipliers: step in stage 1, velocity terms in stage 2, height and bounce in stage 4
// reset: synchronous active low; clears stage valid bits and loads register defaults
`include "particle_euler_bounce_step_defines.svh"

module particle_euler_bounce_step (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  peb_pkg::t_in_item           i_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output peb_pkg::t_out_item          o_data,
    input  logic                        i_cfg_we,
    input  logic [peb_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  logic [31:0]                 i_cfg_wdata
);

    logic [23:0]        r_time_scale;
    logic signed [31:0] r_gravity;

    logic en;

    // stage valid bits
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    // stage 1
    peb_pkg::t_in_item r_s1_in;
    logic [23:0]       r_s1_step;
    logic [39:0]       w_step_prod;

    // stage 2
    logic signed [31:0] r_s2_px, r_s2_py, r_s2_pz, r_s2_vx, r_s2_vy, r_s2_vz;
    logic [23:0]        r_s2_step;
    logic signed [40:0] r_s2_gterm, r_s2_xterm, r_s2_zterm;
    logic signed [24:0] r_s2_life;

    // stage 3
    logic signed [31:0] r_s3_px, r_s3_py, r_s3_pz, r_s3_vx, r_s3_vy, r_s3_vz;
    logic [23:0]        r_s3_step;
    logic               r_s3_expire;
    logic [16:0]        r_s3_life;

    // stage 4
    logic signed [31:0] r_s4_px, r_s4_py, r_s4_pz, r_s4_vx, r_s4_vy, r_s4_vz, r_s4_bounce;
    logic signed [40:0] r_s4_yterm;
    logic               r_s4_expire;
    logic [16:0]        r_s4_life;
    logic signed [48:0] w_bprod;
    logic signed [32:0] w_bterm;
    logic signed [32:0] w_bneg;

    // stage 5
    peb_pkg::t_out_item r_out;
    peb_pkg::t_out_item n_out;
    logic signed [31:0] w_py5;

    assign o_stall = r_v5 & i_stall;
    assign en      = ~o_stall;
    assign o_valid = r_v5;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_scale <= peb_pkg::TIME_SCALE_RST;
            r_gravity    <= peb_pkg::GRAVITY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                peb_pkg::CFG_TIME_SCALE: r_time_scale <= i_cfg_wdata[23:0];
                peb_pkg::CFG_GRAVITY:    r_gravity    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    assign w_step_prod = {24'd0, i_data.frame_time} * {16'd0, r_time_scale};

    // stage 1: frame step
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_in   <= i_data;
            r_s1_step <= w_step_prod[39:16];
        end
    end

    // stage 2: gravity and horizontal position terms, life decrement
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_px    <= r_s1_in.pos_x_in;
            r_s2_py    <= r_s1_in.pos_y_in;
            r_s2_pz    <= r_s1_in.pos_z_in;
            r_s2_vx    <= r_s1_in.vel_x_in;
            r_s2_vy    <= r_s1_in.vel_y_in;
            r_s2_vz    <= r_s1_in.vel_z_in;
            r_s2_step  <= r_s1_step;
            r_s2_gterm <= peb_pkg::mul_step(r_gravity, r_s1_step);
            r_s2_xterm <= peb_pkg::mul_step(r_s1_in.vel_x_in, r_s1_step);
            r_s2_zterm <= peb_pkg::mul_step(r_s1_in.vel_z_in, r_s1_step);
            r_s2_life  <= $signed({8'd0, r_s1_in.life_in})
                          - $signed({2'd0, r_s1_step[23:1]});
        end
    end

    // stage 3: saturated sums, expiry check
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_px     <= peb_pkg::sat32(peb_pkg::add_term(r_s2_px, r_s2_xterm));
            r_s3_pz     <= peb_pkg::sat32(peb_pkg::add_term(r_s2_pz, r_s2_zterm));
            r_s3_vy     <= peb_pkg::sat32(peb_pkg::add_term(r_s2_vy, r_s2_gterm));
            r_s3_py     <= r_s2_py;
            r_s3_vx     <= r_s2_vx;
            r_s3_vz     <= r_s2_vz;
            r_s3_step   <= r_s2_step;
            r_s3_expire <= r_s2_life[24] || (r_s2_life == 25'sd0);
            r_s3_life   <= r_s2_life[16:0];
        end
    end

    // stage 4: height term and bounce velocity
    assign w_bprod = $signed({{17{r_s3_vy[31]}}, r_s3_vy})
                     * $signed({32'd0, peb_pkg::BOUNCE_Q16});
    assign w_bterm = w_bprod[48:16];
    assign w_bneg  = -w_bterm;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_yterm  <= peb_pkg::mul_step(r_s3_vy, r_s3_step);
            r_s4_bounce <= w_bneg[31:0];
            r_s4_px     <= r_s3_px;
            r_s4_py     <= r_s3_py;
            r_s4_pz     <= r_s3_pz;
            r_s4_vx     <= r_s3_vx;
            r_s4_vy     <= r_s3_vy;
            r_s4_vz     <= r_s3_vz;
            r_s4_expire <= r_s3_expire;
            r_s4_life   <= r_s3_life;
        end
    end

    // stage 5: height sum, ground clamp, respawn
    assign w_py5 = peb_pkg::sat32(peb_pkg::add_term(r_s4_py, r_s4_yterm));

    always_comb begin
        n_out.pos_x_out = r_s4_px;
        n_out.pos_z_out = r_s4_pz;
        n_out.vel_x_out = r_s4_vx;
        n_out.vel_z_out = r_s4_vz;
        n_out.pos_y_out = w_py5;
        n_out.vel_y_out = r_s4_vy;
        n_out.life_out  = r_s4_life;
        if (w_py5[31]) begin
            n_out.pos_y_out = 32'sd0;
            n_out.vel_y_out = r_s4_bounce;
        end
        if (r_s4_expire) begin
            n_out.pos_y_out = peb_pkg::RESPAWN_Y;
            n_out.life_out  = peb_pkg::LIFE_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    `PEB_ASSERT_NOW(a_stall_only_when_full, o_stall, o_valid)
    `PEB_ASSERT_NEXT(a_stage4_reaches_output, r_v4 && !o_stall, o_valid)
    `PEB_ASSERT_NEXT(a_expire_respawns, r_v4 && r_s4_expire && !o_stall, o_data.pos_y_out == peb_pkg::RESPAWN_Y && o_data.life_out == peb_pkg::LIFE_FULL)
    `PEB_ASSERT_NOW(a_height_not_negative, o_valid, !o_data.pos_y_out[31])
    `PEB_ASSERT_NOW(a_life_positive, o_valid, o_data.life_out != 17'd0)

endmodule
